// File: src/thcc_pkg.sv
// Shared types and constants of the thermal channel command controller.
package thcc_pkg;

  localparam int unsigned CHANNEL_COUNT = 4;
  localparam int unsigned DUTY_W        = 7;
  localparam int unsigned S_TDATA_W     = 56;
  localparam int unsigned M_TDATA_W     = 32;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SAFE_OFF   = 3'd1,
    OP_SET_POWER  = 3'd2,
    OP_ENABLE     = 3'd3,
    OP_DISABLE    = 3'd4,
    OP_GET_STATUS = 3'd5,
    OP_SELF_TEST  = 3'd6,
    OP_UNKNOWN    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    RSP_NONE = 2'd0,
    RSP_DONE = 2'd1,
    RSP_NACK = 2'd2
  } rsp_t;

  typedef enum logic [2:0] {
    ERR_NONE            = 3'd0,
    ERR_INVALID_PARAM   = 3'd1,
    ERR_INVALID_CHANNEL = 3'd2,
    ERR_DEVICE_BUSY     = 3'd3,
    ERR_UNKNOWN_CMD     = 3'd4
  } err_t;

  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET = 7'd100;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted input word
    logic exec;  // apply the held command and load the result register
  } thcc_cmd_t;

endpackage

// File: src/thermal_channel_command_controller.sv
// Top level of the thermal channel command controller.
//
//  port group  | dir | tdata (low bit up)                         | tuser
//  ------------+-----+--------------------------------------------+------------------
//  s_*         | in  | channel_number, duty_byte, param_rest,     | operation
//              |     | fault_inputs, zero pad                     |
//  m_*         | out | error_code, echo_operation, done_data,     | response
//              |     | drive duties 1/2, heaters 0/3, faults, pad |
//  duty_limit_*| in  | 7-bit duty limit, written when wen is high | -
//
// Each word is captured in the idle state, then the command is applied
// through the controller's execute state, which loads the result register.
// The result register parts the two sides: the next word is taken while a
// result waits, and only the execute step holds for a stalled m_tready.
// rst is synchronous: it clears the channel state, fault latches and valid,
// and reloads duty_limit with 100.
module thermal_channel_command_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // channel_number[7:0], duty_byte[15:8], param_rest[47:16],
  // fault_inputs[49:48], zero [55:50]
  input  logic [thcc_pkg::S_TDATA_W-1:0]    s_tdata,
  // operation[2:0]
  input  logic [2:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // error_code[2:0], echo_operation[5:3], done_data[7:6],
  // drive_duty_first[14:8], drive_duty_second[21:15], disk_heater_on[22],
  // glass_heater_on[23], fault_status[25:24], zero [31:26]
  output logic [thcc_pkg::M_TDATA_W-1:0]    m_tdata,
  // response[1:0]
  output logic [1:0]                        m_tuser,
  input  logic                              duty_limit_wen,
  input  logic [thcc_pkg::DUTY_W-1:0]       duty_limit_wdata
);
  import thcc_pkg::*;

  thcc_cmd_t         cmd;
  logic [2:0]        error_code;
  logic [2:0]        echo_operation;
  logic [1:0]        done_data;
  logic [DUTY_W-1:0] duty_first;
  logic [DUTY_W-1:0] duty_second;
  logic              disk_on;
  logic              glass_on;
  logic [1:0]        fault_status;

  thcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  thcc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .in_operation     (s_tuser),
    .in_channel       (s_tdata[7:0]),
    .in_duty          (s_tdata[15:8]),
    .in_rest          (s_tdata[47:16]),
    .in_faults        (s_tdata[49:48]),
    .duty_limit_wen   (duty_limit_wen),
    .duty_limit_wdata (duty_limit_wdata),
    .out_response     (m_tuser),
    .out_error        (error_code),
    .out_operation    (echo_operation),
    .out_done_data    (done_data),
    .out_duty_first   (duty_first),
    .out_duty_second  (duty_second),
    .out_disk_on      (disk_on),
    .out_glass_on     (glass_on),
    .out_fault_status (fault_status)
  );

  // pack the result word, zero padded to whole bytes
  assign m_tdata = {6'd0, fault_status, glass_on, disk_on, duty_second, duty_first,
                    done_data, echo_operation, error_code};

endmodule

// File: src/thcc_ctrl.sv
// Controller state machine: input handshake, execute sequencing, result valid.
module thcc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output thcc_pkg::thcc_cmd_t cmd
);
  import thcc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: src/thcc_dp.sv
// Datapath: input register, channel state, command checks and result register.
module thcc_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  thcc_pkg::thcc_cmd_t                  cmd,
  input  logic [2:0]                           in_operation,
  input  logic [7:0]                           in_channel,
  input  logic [7:0]                           in_duty,
  input  logic [31:0]                          in_rest,
  input  logic [1:0]                           in_faults,
  input  logic                                 duty_limit_wen,
  input  logic [thcc_pkg::DUTY_W-1:0]          duty_limit_wdata,
  output logic [1:0]                           out_response,
  output logic [2:0]                           out_error,
  output logic [2:0]                           out_operation,
  output logic [1:0]                           out_done_data,
  output logic [thcc_pkg::DUTY_W-1:0]          out_duty_first,
  output logic [thcc_pkg::DUTY_W-1:0]          out_duty_second,
  output logic                                 out_disk_on,
  output logic                                 out_glass_on,
  output logic [1:0]                           out_fault_status
);
  import thcc_pkg::*;

  // held input word
  op_t         op;
  logic [7:0]  channel;
  logic [7:0]  duty;
  logic [31:0] rest;
  logic [1:0]  faults;

  // channel state; only the Peltier duties can ever be nonzero
  logic [DUTY_W-1:0]        duty_limit;
  logic [DUTY_W-1:0]        duty_first;
  logic [DUTY_W-1:0]        duty_second;
  logic [CHANNEL_COUNT-1:0] enabled;
  logic [1:0]               fault_latch;

  logic [DUTY_W-1:0]        duty_first_next;
  logic [DUTY_W-1:0]        duty_second_next;
  logic [CHANNEL_COUNT-1:0] enabled_next;
  logic [1:0]               fault_latch_next;
  rsp_t                     rsp;
  err_t                     err;
  logic [1:0]               done_data;

  logic [1:0]               chi;
  logic                     ch_ok;
  logic                     zero_param;
  logic                     peltier;
  logic                     latched;
  logic                     duty_bad;
  logic [CHANNEL_COUNT-1:0] ch_bit;
  logic [CHANNEL_COUNT-1:0] en_sampled;

  always_comb begin
    chi              = channel[1:0];
    ch_ok            = (channel[7:2] == 6'd0);
    zero_param       = (duty == 8'd0) && (rest == 32'd0);
    peltier          = (chi == 2'd1) || (chi == 2'd2);
    ch_bit           = CHANNEL_COUNT'(1) << chi;
    duty_bad         = duty > {1'b0, duty_limit};
    // sample faults first: latch and drop the enable of a faulty channel
    fault_latch_next = fault_latch | faults;
    en_sampled       = enabled & ~{1'b0, faults, 1'b0};
    latched          = ((chi == 2'd1) && fault_latch_next[0]) ||
                       ((chi == 2'd2) && fault_latch_next[1]);

    enabled_next     = en_sampled;
    duty_first_next  = duty_first;
    duty_second_next = duty_second;
    rsp              = RSP_NACK;
    err              = ERR_NONE;
    done_data        = 2'd0;

    priority if (op == OP_TICK) begin
      rsp = RSP_NONE;
    end else if (op == OP_SAFE_OFF) begin
      if (!zero_param) begin
        err = ERR_INVALID_PARAM;
      end else begin
        enabled_next     = '0;
        duty_first_next  = '0;
        duty_second_next = '0;
        rsp              = RSP_DONE;
      end
    end else if (!ch_ok) begin
      err = ERR_INVALID_CHANNEL;
    end else begin
      unique case (op)
        OP_SET_POWER: begin
          if (!peltier || (rest != 32'd0) || duty_bad) begin
            err = ERR_INVALID_PARAM;
          end else if (latched) begin
            err = ERR_DEVICE_BUSY;
          end else begin
            if (chi == 2'd1) begin
              duty_first_next = duty[DUTY_W-1:0];
            end else begin
              duty_second_next = duty[DUTY_W-1:0];
            end
            rsp       = RSP_DONE;
            done_data = chi;
          end
        end
        OP_ENABLE: begin
          if (!zero_param) begin
            err = ERR_INVALID_PARAM;
          end else if (latched) begin
            err = ERR_DEVICE_BUSY;
          end else begin
            enabled_next = en_sampled | ch_bit;
            rsp          = RSP_DONE;
            done_data    = chi;
          end
        end
        OP_DISABLE: begin
          if (!zero_param) begin
            err = ERR_INVALID_PARAM;
          end else begin
            enabled_next = en_sampled & ~ch_bit;
            rsp          = RSP_DONE;
            done_data    = chi;
          end
        end
        OP_GET_STATUS: err = ERR_DEVICE_BUSY;
        OP_TICK, OP_SAFE_OFF, OP_SELF_TEST, OP_UNKNOWN: err = ERR_UNKNOWN_CMD;
        default: err = ERR_UNKNOWN_CMD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= op_t'(in_operation);
      channel <= in_channel;
      duty    <= in_duty;
      rest    <= in_rest;
      faults  <= in_faults;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_limit  <= DUTY_LIMIT_RESET;
      duty_first  <= '0;
      duty_second <= '0;
      enabled     <= '0;
      fault_latch <= '0;
    end else begin
      if (duty_limit_wen) begin
        duty_limit <= duty_limit_wdata;
      end
      if (cmd.exec) begin
        duty_first  <= duty_first_next;
        duty_second <= duty_second_next;
        enabled     <= enabled_next;
        fault_latch <= fault_latch_next;
      end
    end
  end

  // result register: drives follow from the state after the command
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_response     <= rsp;
      out_error        <= err;
      out_operation    <= op;
      out_done_data    <= done_data;
      out_duty_first   <= enabled_next[1] ? duty_first_next : '0;
      out_duty_second  <= enabled_next[2] ? duty_second_next : '0;
      out_disk_on      <= enabled_next[0];
      out_glass_on     <= enabled_next[3];
      out_fault_status <= fault_latch_next;
    end
  end

endmodule
